FILE: src/clf_pkg.sv
// ----------------------------------------------------------------------------
// clf_pkg
// Shared constants and types of the charger link frame parser: frame layout,
// status and function codes, and the frame snapshot handed to the decoder.
// ----------------------------------------------------------------------------
package clf_pkg;

    // frame layout
    localparam logic [7:0]  START_MARK = 8'h68;
    localparam int unsigned LEN_EXTRA  = 12;
    localparam logic [7:0]  STOP_TYPE  = 8'h03;
    localparam int unsigned PAY_FIRST  = 11;
    localparam int unsigned PAY_DEPTH  = 21;
    localparam int unsigned IDX_W      = 17;
    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    // header byte positions
    localparam logic [IDX_W-1:0] POS_START = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_CODE  = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_TYPE  = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_LEN_H = IDX_W'(9);
    localparam logic [IDX_W-1:0] POS_LEN_L = IDX_W'(10);

    // frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HEAD = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_BAD_SUM  = 2'd3;

    // function codes
    localparam logic [7:0] FC_LINK     = 8'd1;
    localparam logic [7:0] FC_ACCOUNT  = 8'd2;
    localparam logic [7:0] FC_LOGIN    = 8'd3;
    localparam logic [7:0] FC_CHARGE   = 8'd4;
    localparam logic [7:0] FC_STOP     = 8'd5;
    localparam logic [7:0] FC_PAY_A    = 8'd6;
    localparam logic [7:0] FC_PAY_B    = 8'd7;
    localparam logic [7:0] FC_SRV_STOP = 8'd8;
    localparam logic [7:0] FC_CARD     = 8'd9;
    localparam logic [7:0] FC_CLOCK    = 8'd10;

    // update mask bits
    localparam logic [4:0] UPD_BAL   = 5'h01;
    localparam logic [4:0] UPD_PAY   = 5'h02;
    localparam logic [4:0] UPD_ORDER = 5'h04;
    localparam logic [4:0] UPD_CLOCK = 5'h08;
    localparam logic [4:0] UPD_CARD  = 5'h10;

    // event mask bits
    localparam logic [6:0] EV_LINK     = 7'h01;
    localparam logic [6:0] EV_ACCOUNT  = 7'h02;
    localparam logic [6:0] EV_LOGIN    = 7'h04;
    localparam logic [6:0] EV_CHARGE   = 7'h08;
    localparam logic [6:0] EV_PERMIT   = 7'h10;
    localparam logic [6:0] EV_SRV_STOP = 7'h20;
    localparam logic [6:0] EV_STOP_OUT = 7'h40;

    typedef logic [PAY_DEPTH-1:0][7:0] t_pay;

    // everything the decoder needs from one finished frame
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  code;
        logic [7:0]  ftype;
        logic [15:0] length;
        t_pay        pay;
    } t_snap;

    // big-endian word starting at payload slot first (frame byte first + 11)
    function automatic logic [31:0] be_word(input t_pay pay, input int unsigned first);
        be_word = {pay[first], pay[first+1], pay[first+2], pay[first+3]};
    endfunction

endpackage

FILE: src/clf_track.sv
// ----------------------------------------------------------------------------
// clf_track
// Per-byte frame tracking: byte index, header capture, payload slots and the
// running data sum. On the last beat the frame is checked and a snapshot is
// registered for the decoder, and the tracking state is cleared.
// ----------------------------------------------------------------------------
module clf_track
    import clf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    output logic        o_snap_vld,
    input  logic        i_snap_take,
    output t_snap       o_snap
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_start_ok, n_start_ok;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_sum, n_sum;
    t_pay             r_pay, n_pay;
    logic             r_snap_vld;
    t_snap            r_snap, n_snap;

    logic             accept;
    logic [IDX_W-1:0] count;
    logic [IDX_W-1:0] expect_cnt;

    assign o_in_ready = !r_snap_vld || i_snap_take;
    assign accept     = i_in_valid && o_in_ready;
    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

    // capture header and payload bytes of the current beat
    always_comb begin
        n_start_ok = r_start_ok;
        n_code     = r_code;
        n_type     = r_type;
        n_len      = r_len;
        n_pay      = r_pay;
        if (r_idx == POS_START) begin
            n_start_ok = (i_rx_byte == START_MARK);
        end else if (r_idx == POS_CODE) begin
            n_code = i_rx_byte;
        end else if (r_idx == POS_TYPE) begin
            n_type = i_rx_byte;
        end else if (r_idx == POS_LEN_H) begin
            n_len[15:8] = i_rx_byte;
        end else if (r_idx == POS_LEN_L) begin
            n_len[7:0] = i_rx_byte;
        end
        for (int k = 0; k < PAY_DEPTH; k++) begin
            if (r_idx == IDX_W'(PAY_FIRST + k)) begin
                n_pay[k] = i_rx_byte;
            end
        end
        n_sum = (r_idx >= IDX_W'(PAY_FIRST)) ? r_sum + i_rx_byte : r_sum;
        n_idx = (r_idx != IDX_MAX) ? r_idx + IDX_W'(1) : IDX_MAX;
    end

    // frame check on the last beat
    assign count      = n_idx;
    assign expect_cnt = IDX_W'({1'b0, n_len}) + IDX_W'(LEN_EXTRA);

    always_comb begin
        n_snap.code   = n_code;
        n_snap.ftype  = n_type;
        n_snap.length = n_len;
        n_snap.pay    = n_pay;
        if (!n_start_ok) begin
            n_snap.status = ST_BAD_HEAD;
        end else if (count != expect_cnt) begin
            n_snap.status = ST_BAD_LEN;
        end else if (r_sum != i_rx_byte) begin
            n_snap.status = ST_BAD_SUM;
        end else begin
            n_snap.status = ST_OK;
        end
    end

    // tracking state: advance per beat, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_start_ok <= 1'b0;
            r_code     <= '0;
            r_type     <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_pay      <= '0;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_idx      <= '0;
                r_start_ok <= 1'b0;
                r_code     <= '0;
                r_type     <= '0;
                r_len      <= '0;
                r_sum      <= '0;
                r_pay      <= '0;
            end else begin
                r_idx      <= n_idx;
                r_start_ok <= n_start_ok;
                r_code     <= n_code;
                r_type     <= n_type;
                r_len      <= n_len;
                r_sum      <= n_sum;
                r_pay      <= n_pay;
            end
        end
    end

    // snapshot register toward the decoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (accept && i_end_of_frame) begin
            r_snap_vld <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_end_of_frame) begin
            r_snap <= n_snap;
        end
    end

endmodule

FILE: src/clf_decode.sv
// ----------------------------------------------------------------------------
// clf_decode
// Decodes a checked frame snapshot by function code into balance, pay, order,
// clock and card fields with update and event masks, and holds the result
// register of the output channel.
// ----------------------------------------------------------------------------
module clf_decode
    import clf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_vld,
    output logic        o_snap_take,
    input  t_snap       i_snap,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_function_code,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_balance,
    output logic [31:0] o_pay_amount,
    output logic [31:0] o_order_id,
    output logic [47:0] o_clock_stamp,
    output logic [7:0]  o_card_state,
    output logic [4:0]  o_updated_fields,
    output logic [6:0]  o_event_flags
);

    logic        r_out_vld;
    logic [1:0]  r_status;
    logic [7:0]  r_code, r_type, r_card;
    logic [15:0] r_len;
    logic [31:0] r_bal, r_pay, r_ord;
    logic [47:0] r_clk;
    logic [4:0]  r_upd;
    logic [6:0]  r_ev;

    logic [31:0] n_bal, n_pay, n_ord;
    logic [47:0] n_clk;
    logic [7:0]  n_card;
    logic [4:0]  n_upd;
    logic [6:0]  n_ev;

    assign o_snap_take = i_snap_vld && (!r_out_vld || i_out_ready);

    // decode by function code, only for a passing frame
    always_comb begin
        n_bal  = '0;
        n_pay  = '0;
        n_ord  = '0;
        n_clk  = '0;
        n_card = '0;
        n_upd  = '0;
        n_ev   = '0;
        if (i_snap.status == ST_OK) begin
            case (i_snap.code)
                FC_LINK: begin
                    n_ev = EV_LINK;
                end
                FC_ACCOUNT: begin
                    n_bal = be_word(i_snap.pay, 12);
                    n_upd = UPD_BAL;
                    n_ev  = EV_LINK | EV_ACCOUNT;
                end
                FC_LOGIN: begin
                    n_bal = be_word(i_snap.pay, 12);
                    n_upd = UPD_BAL;
                    n_ev  = EV_LOGIN;
                end
                FC_CHARGE: begin
                    if (i_snap.ftype == 8'h00) begin
                        n_ord = be_word(i_snap.pay, 0);
                        n_bal = be_word(i_snap.pay, 4);
                        n_upd = UPD_BAL | UPD_ORDER;
                        n_ev  = EV_CHARGE;
                    end
                end
                FC_STOP: begin
                    n_bal = be_word(i_snap.pay, 0);
                    n_pay = be_word(i_snap.pay, 4);
                    n_upd = UPD_BAL | UPD_PAY;
                    n_ev  = EV_PERMIT;
                end
                FC_PAY_A, FC_PAY_B: begin
                    n_pay = be_word(i_snap.pay, 0);
                    n_upd = UPD_PAY;
                    n_ev  = (i_snap.ftype == STOP_TYPE) ? (EV_LINK | EV_STOP_OUT) : EV_LINK;
                end
                FC_SRV_STOP: begin
                    n_ev = EV_LINK | EV_SRV_STOP | EV_STOP_OUT;
                end
                FC_CARD: begin
                    n_bal  = be_word(i_snap.pay, 16);
                    n_card = i_snap.pay[20];
                    n_upd  = UPD_BAL | UPD_CARD;
                    n_ev   = EV_LINK;
                end
                FC_CLOCK: begin
                    n_clk = {i_snap.pay[0], i_snap.pay[1], i_snap.pay[2],
                             i_snap.pay[3], i_snap.pay[4], i_snap.pay[5]};
                    n_upd = UPD_CLOCK;
                    n_ev  = EV_LINK;
                end
                default: begin
                    n_ev = '0;
                end
            endcase
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_snap_take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_status <= i_snap.status;
            r_code   <= i_snap.code;
            r_type   <= i_snap.ftype;
            r_len    <= i_snap.length;
            r_bal    <= n_bal;
            r_pay    <= n_pay;
            r_ord    <= n_ord;
            r_clk    <= n_clk;
            r_card   <= n_card;
            r_upd    <= n_upd;
            r_ev     <= n_ev;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_frame_status   = r_status;
    assign o_function_code  = r_code;
    assign o_frame_type     = r_type;
    assign o_payload_length = r_len;
    assign o_balance        = r_bal;
    assign o_pay_amount     = r_pay;
    assign o_order_id       = r_ord;
    assign o_clock_stamp    = r_clk;
    assign o_card_state     = r_card;
    assign o_updated_fields = r_upd;
    assign o_event_flags    = r_ev;

endmodule

FILE: src/charger_link_frame_parser.sv
// A frame's last beat is registered in the snapshot register, then decoded into the
// result register that drives its result beat.
// Throughput: one byte per cycle while the input is not stalled; each frame gives one result.
// The input stalls only while a finished frame waits in the snapshot register
// behind a result beat that the receiver has not taken.
// Reset (synchronous, active low) clears the frame state and empties the result
// and snapshot registers.
// ----------------------------------------------------------------------------
// charger_link_frame_parser
// Checks received link frames byte by byte and reports status and decoded
// account, payment, order, clock and card fields after the last byte.
// ----------------------------------------------------------------------------
module charger_link_frame_parser
    import clf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_function_code,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_balance,
    output logic [31:0] o_pay_amount,
    output logic [31:0] o_order_id,
    output logic [47:0] o_clock_stamp,
    output logic [7:0]  o_card_state,
    output logic [4:0]  o_updated_fields,
    output logic [6:0]  o_event_flags
);

    logic  snap_vld;
    logic  snap_take;
    t_snap snap;

    // byte tracking and frame check
    clf_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_snap_vld     (snap_vld),
        .i_snap_take    (snap_take),
        .o_snap         (snap)
    );

    // field decode and result register
    clf_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap_vld       (snap_vld),
        .o_snap_take      (snap_take),
        .i_snap           (snap),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frame_status   (o_frame_status),
        .o_function_code  (o_function_code),
        .o_frame_type     (o_frame_type),
        .o_payload_length (o_payload_length),
        .o_balance        (o_balance),
        .o_pay_amount     (o_pay_amount),
        .o_order_id       (o_order_id),
        .o_clock_stamp    (o_clock_stamp),
        .o_card_state     (o_card_state),
        .o_updated_fields (o_updated_fields),
        .o_event_flags    (o_event_flags)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for charger_link_frame_parser: feeds link bytes framed
// by end-of-frame flags, predicts each frame report in a local byte tracker,
// and compares every report beat field by field under random flow control.
// ----------------------------------------------------------------------------
module tb;
    import clf_pkg::*;

    localparam int IDLE_PCT       = 29;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_GAP      = 8;
    localparam int RANDOM_BEATS   = 180;
    localparam int RANDOM_FRAMES  = 8;
    localparam int MAX_REPORTS    = 10;

    // payload word positions per function code
    localparam int unsigned POS_ACCT_BAL  = 23;
    localparam int unsigned POS_CHG_ORDER = 11;
    localparam int unsigned POS_CHG_BAL   = 15;
    localparam int unsigned POS_STOP_BAL  = 11;
    localparam int unsigned POS_STOP_PAY  = 15;
    localparam int unsigned POS_PAY       = 11;
    localparam int unsigned POS_CARD_BAL  = 27;
    localparam int unsigned POS_CARD_ST   = 31;
    localparam int unsigned POS_STAMP     = 11;

    // how the final byte of a generated frame is chosen
    typedef enum logic [1:0] {CK_GOOD, CK_BAD, CK_RAND} t_ck_mode;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  code;
        logic [7:0]  ftype;
        logic [15:0] length;
        logic [31:0] balance;
        logic [31:0] pay;
        logic [31:0] order;
        logic [47:0] stamp;
        logic [7:0]  card;
        logic [4:0]  upd;
        logic [6:0]  ev;
    } t_frame_report;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_rx_byte      = 8'h00;
    logic        i_end_of_frame = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_frame_status;
    logic [7:0]  o_function_code;
    logic [7:0]  o_frame_type;
    logic [15:0] o_payload_length;
    logic [31:0] o_balance;
    logic [31:0] o_pay_amount;
    logic [31:0] o_order_id;
    logic [47:0] o_clock_stamp;
    logic [7:0]  o_card_state;
    logic [4:0]  o_updated_fields;
    logic [6:0]  o_event_flags;

    // tracker state
    logic [IDX_W-1:0] pos;
    logic             head_ok;
    logic [7:0]       code_q;
    logic [7:0]       type_q;
    logic [15:0]      len_q;
    logic [7:0]       sum_q;
    logic [7:0]       store [PAY_DEPTH];

    t_frame_report report_q[$];
    int            n_bad       = 0;
    int            beats_sent  = 0;
    bit            quiet       = 1'b0;
    int            hold_ticket = 0;
    int            hold_seen   = 0;
    int            hold_left   = 0;
    int            idle_cnt    = 0;

    charger_link_frame_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_end_of_frame   (i_end_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frame_status   (o_frame_status),
        .o_function_code  (o_function_code),
        .o_frame_type     (o_frame_type),
        .o_payload_length (o_payload_length),
        .o_balance        (o_balance),
        .o_pay_amount     (o_pay_amount),
        .o_order_id       (o_order_id),
        .o_clock_stamp    (o_clock_stamp),
        .o_card_state     (o_card_state),
        .o_updated_fields (o_updated_fields),
        .o_event_flags    (o_event_flags)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // frame tracker
    // ------------------------------------------------------------------------
    task automatic clear_frame();
        pos     = '0;
        head_ok = 1'b0;
        code_q  = '0;
        type_q  = '0;
        len_q   = '0;
        sum_q   = '0;
        foreach (store[k]) store[k] = 8'h00;
    endtask

    // big-endian word from frame byte position p
    function automatic logic [31:0] store_word(input int unsigned p);
        store_word = {store[p - PAY_FIRST], store[p + 1 - PAY_FIRST],
                      store[p + 2 - PAY_FIRST], store[p + 3 - PAY_FIRST]};
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic eof);
        t_frame_report    r;
        logic [IDX_W-1:0] idx;
        int unsigned      count;
        idx = pos;
        if (idx == POS_START) head_ok = (b == START_MARK);
        else if (idx == POS_CODE) code_q = b;
        else if (idx == POS_TYPE) type_q = b;
        else if (idx == POS_LEN_H) len_q[15:8] = b;
        else if (idx == POS_LEN_L) len_q[7:0] = b;
        if (idx >= PAY_FIRST && idx < PAY_FIRST + PAY_DEPTH) store[idx - PAY_FIRST] = b;

        // mid-frame byte: accumulate only
        if (!eof) begin
            if (idx >= PAY_FIRST) sum_q = sum_q + b;
            if (pos != IDX_MAX) pos = pos + 1'b1;
            return;
        end

        count = (idx != IDX_MAX) ? int'(idx) + 1 : int'(IDX_MAX);
        r = '0;
        r.code   = code_q;
        r.ftype  = type_q;
        r.length = len_q;
        if (!head_ok) r.status = ST_BAD_HEAD;
        else if (count != int'(len_q) + LEN_EXTRA) r.status = ST_BAD_LEN;
        else if (sum_q != b) r.status = ST_BAD_SUM;
        else r.status = ST_OK;

        // decode of a passing frame
        if (r.status == ST_OK) begin
            case (code_q)
                FC_LINK: r.ev = EV_LINK;
                FC_ACCOUNT: begin
                    r.balance = store_word(POS_ACCT_BAL);
                    r.upd     = UPD_BAL;
                    r.ev      = EV_LINK | EV_ACCOUNT;
                end
                FC_LOGIN: begin
                    r.balance = store_word(POS_ACCT_BAL);
                    r.upd     = UPD_BAL;
                    r.ev      = EV_LOGIN;
                end
                FC_CHARGE: begin
                    if (type_q == 8'h00) begin
                        r.order   = store_word(POS_CHG_ORDER);
                        r.balance = store_word(POS_CHG_BAL);
                        r.upd     = UPD_ORDER | UPD_BAL;
                        r.ev      = EV_CHARGE;
                    end
                end
                FC_STOP: begin
                    r.balance = store_word(POS_STOP_BAL);
                    r.pay     = store_word(POS_STOP_PAY);
                    r.upd     = UPD_BAL | UPD_PAY;
                    r.ev      = EV_PERMIT;
                end
                FC_PAY_A, FC_PAY_B: begin
                    r.pay = store_word(POS_PAY);
                    r.upd = UPD_PAY;
                    r.ev  = EV_LINK;
                    if (type_q == STOP_TYPE) r.ev = r.ev | EV_STOP_OUT;
                end
                FC_SRV_STOP: r.ev = EV_LINK | EV_SRV_STOP | EV_STOP_OUT;
                FC_CARD: begin
                    r.balance = store_word(POS_CARD_BAL);
                    r.card    = store[POS_CARD_ST - PAY_FIRST];
                    r.upd     = UPD_BAL | UPD_CARD;
                    r.ev      = EV_LINK;
                end
                FC_CLOCK: begin
                    for (int j = 0; j < 6; j++)
                        r.stamp = {r.stamp[39:0], store[POS_STAMP - PAY_FIRST + j]};
                    r.upd = UPD_CLOCK;
                    r.ev  = EV_LINK;
                end
                default: ;
            endcase
        end
        report_q.push_back(r);
        clear_frame();
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic eof);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_rx_byte      <= b;
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (!o_in_ready);
        track_byte(b, eof);
        beats_sent++;
    endtask

    // one frame of nbytes; header bytes placed where the frame reaches them
    task automatic send_frame(input logic [7:0] head, input logic [7:0] code,
                              input logic [7:0] ftype, input logic [15:0] len_field,
                              input int unsigned nbytes, input t_ck_mode ck,
                              input bit fill_fixed, input logic [7:0] fill_val);
        logic [7:0]  b;
        logic [7:0]  run_sum;
        int unsigned i;
        run_sum = 8'h00;
        for (i = 0; i < nbytes; i++) begin
            b = fill_fixed ? fill_val : 8'($urandom);
            if (i == POS_START) b = head;
            else if (i == POS_CODE) b = code;
            else if (i == POS_TYPE) b = ftype;
            else if (i == POS_LEN_H) b = len_field[15:8];
            else if (i == POS_LEN_L) b = len_field[7:0];
            if (i == nbytes - 1) begin
                if (ck == CK_GOOD) b = run_sum;
                else if (ck == CK_BAD) b = run_sum ^ 8'($urandom_range(1, 255));
            end else if (i >= PAY_FIRST) begin
                run_sum = run_sum + b;
            end
            send_beat(b, i == nbytes - 1);
        end
    endtask

    task automatic send_good(input logic [7:0] code, input logic [7:0] ftype,
                             input logic [15:0] len);
        send_frame(START_MARK, code, ftype, len, int'(len) + LEN_EXTRA, CK_GOOD, 1'b0, 8'h00);
    endtask

    // sender stops until every report is back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    // ready with random holes, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each report beat with the oldest prediction
    always @(posedge i_clk) begin
        t_frame_report want;
        t_frame_report got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_frame_status, o_function_code, o_frame_type, o_payload_length,
                    o_balance, o_pay_amount, o_order_id, o_clock_stamp, o_card_state,
                    o_updated_fields, o_event_flags};
            if (report_q.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected report beat: st=%0d fc=%h ty=%h len=%h",
                             got.status, got.code, got.ftype, got.length);
            end else begin
                want = report_q.pop_front();
                if (got.status !== want.status || got.code !== want.code ||
                    got.ftype !== want.ftype || got.length !== want.length ||
                    got.balance !== want.balance || got.pay !== want.pay ||
                    got.order !== want.order || got.stamp !== want.stamp ||
                    got.card !== want.card || got.upd !== want.upd ||
                    got.ev !== want.ev) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("mismatch exp: st=%0d fc=%h ty=%h len=%h bal=%h pay=%h",
                                 want.status, want.code, want.ftype, want.length,
                                 want.balance, want.pay);
                        $display("             ord=%h clk=%h card=%h upd=%h ev=%h",
                                 want.order, want.stamp, want.card, want.upd, want.ev);
                        $display("mismatch got: st=%0d fc=%h ty=%h len=%h bal=%h pay=%h",
                                 got.status, got.code, got.ftype, got.length,
                                 got.balance, got.pay);
                        $display("             ord=%h clk=%h card=%h upd=%h ev=%h",
                                 got.order, got.stamp, got.card, got.upd, got.ev);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cnt = 0;
        else
            idle_cnt = idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // every function code and type variant, and unknown codes, on well-formed frames
    task automatic test_decode();
        send_good(FC_LINK, 8'($urandom), 16'd0);
        send_good(FC_ACCOUNT, 8'($urandom), 16'd16);
        send_good(FC_LOGIN, 8'($urandom), 16'd16);
        send_good(FC_CHARGE, 8'h00, 16'd8);
        send_good(FC_CHARGE, 8'h01, 16'd8);
        send_good(FC_STOP, 8'($urandom), 16'd8);
        send_good(FC_PAY_A, STOP_TYPE, 16'd4);
        send_good(FC_PAY_A, 8'h00, 16'd4);
        send_good(FC_PAY_B, STOP_TYPE, 16'd4);
        send_good(FC_PAY_B, 8'h04, 16'd4);
        send_good(FC_SRV_STOP, 8'($urandom), 16'd0);
        send_good(FC_CARD, 8'($urandom), 16'd21);
        send_good(FC_CLOCK, 8'($urandom), 16'd6);
        send_good(8'h00, 8'h00, 16'd3);
        send_good(FC_CLOCK + 8'd1, 8'h00, 16'd3);
        // all-ones and all-zeros content
        send_frame(START_MARK, 8'hFF, 8'hFF, 16'd21, 33, CK_GOOD, 1'b1, 8'hFF);
        send_frame(START_MARK, FC_CARD, 8'hFF, 16'd21, 33, CK_GOOD, 1'b1, 8'hFF);
        send_frame(START_MARK, FC_CLOCK, 8'hFF, 16'd6, 18, CK_GOOD, 1'b1, 8'hFF);
        send_frame(START_MARK, FC_STOP, 8'h00, 16'd8, 20, CK_GOOD, 1'b1, 8'h00);
        wait_results_done();
    endtask

    // bad start, length and checksum, short frames, checksum in the payload window
    task automatic test_frame_errors();
        send_frame(8'h00, FC_LINK, 8'h00, 16'd0, 12, CK_GOOD, 1'b0, 8'h00);
        send_frame(8'hFF, FC_STOP, 8'h00, 16'd8, 20, CK_GOOD, 1'b0, 8'h00);
        send_frame(START_MARK, FC_LINK, 8'h00, 16'd5, 16, CK_GOOD, 1'b0, 8'h00);
        send_frame(START_MARK, FC_LINK, 8'h00, 16'd5, 18, CK_GOOD, 1'b0, 8'h00);
        send_frame(START_MARK, FC_ACCOUNT, 8'h00, 16'd16, 28, CK_BAD, 1'b0, 8'h00);
        send_frame(START_MARK, FC_LINK, 8'h00, 16'hFFFF, 11, CK_GOOD, 1'b0, 8'h00);
        send_frame(START_MARK, FC_LINK, 8'h00, 16'd0, 1, CK_RAND, 1'b0, 8'h00);
        send_frame(8'($urandom), FC_LINK, 8'h00, 16'd0, 1, CK_RAND, 1'b0, 8'h00);
        send_frame(START_MARK, FC_CARD, 8'h00, 16'd0, 5, CK_RAND, 1'b0, 8'h00);
        // checksum byte read as payload, missing bytes read as zero
        send_good(FC_STOP, 8'h00, 16'd2);
        send_good(FC_CARD, 8'h00, 16'd20);
        send_good(FC_CLOCK, 8'h00, 16'd0);
        send_good(FC_CHARGE, 8'h00, 16'd1);
        wait_results_done();
    endtask

    // hold the report side off while one-byte frames and some link frames keep coming
    task automatic test_backpressure();
        hold_ticket++;
        for (int n = 0; n < 40; n++) begin
            if (n % 8 == 7) send_good(FC_LINK, 8'h00, 16'd0);
            else send_beat(8'($urandom), 1'b1);
        end
        wait_results_done();
    endtask

    // mostly well-formed frames with random content, some broken and noise
    task automatic test_random_frames();
        int          start_beats;
        int          frames;
        int          r;
        logic [7:0]  code;
        logic [7:0]  ftype;
        logic [15:0] len;
        start_beats = beats_sent;
        frames      = 0;
        while (beats_sent - start_beats < RANDOM_BEATS || frames < RANDOM_FRAMES) begin
            quiet = (frames >= 2 && frames < 6);
            r     = $urandom_range(0, 99);
            code  = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
            r     = r;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ftype = 8'h00;
                4, 5, 6:    ftype = STOP_TYPE;
                default:    ftype = 8'($urandom);
            endcase
            len = 16'($urandom_range(0, 30));
            if (r < 75) begin
                send_frame(START_MARK, code, ftype, len, int'(len) + LEN_EXTRA,
                           ($urandom_range(0, 9) == 0) ? CK_BAD : CK_GOOD, 1'b0, 8'h00);
            end else if (r < 90) begin
                send_frame(START_MARK, code, ftype, len, $urandom_range(1, 45),
                           CK_GOOD, 1'b0, 8'h00);
            end else begin
                send_frame($urandom_range(0, 1) ? START_MARK : 8'($urandom), 8'($urandom),
                           8'($urandom), 16'($urandom), $urandom_range(1, 40),
                           CK_RAND, 1'b0, 8'h00);
            end
            frames++;
        end
        quiet = 1'b0;
        wait_results_done();
    endtask

    // frames running well past the payload window, one passing, one overlong
    task automatic test_long_frames();
        quiet = 1'b1;
        send_good(FC_CLOCK, 8'h00, 16'd60);
        send_frame(START_MARK, FC_LINK, 8'h00, 16'd8, 90, CK_RAND, 1'b0, 8'h00);
        quiet = 1'b0;
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_frame();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_decode();
        test_frame_errors();
        test_backpressure();
        test_random_frames();
        test_long_frames();
        n_bad += report_q.size();
        if (n_bad == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
